>>> design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SBCU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SBCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/sbcu_pkg.sv
// types, charset codes and code point tables for the transcoder
package sbcu_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 16;
    localparam int unsigned SEL_W  = 2;

    localparam logic [SEL_W-1:0] CS_LATIN9  = 2'd0;
    localparam logic [SEL_W-1:0] CS_LATIN1  = 2'd1;
    localparam logic [SEL_W-1:0] CS_WIN1252 = 2'd2;

    // windows-1252 code points for bytes 0x80..0x9f
    localparam logic [CP_W-1:0] WIN1252_LOW [32] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] cp;
    } t_cp_word;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [1:0]        count;
        logic              nul;
    } t_enc_word;

    function automatic logic [CP_W-1:0] f_code_point(
        input logic [SEL_W-1:0]  sel,
        input logic [BYTE_W-1:0] b
    );
        logic [CP_W-1:0] cp;
        cp = {8'h00, b};
        if (b[7]) begin
            case (sel)
                CS_LATIN9: begin
                    case (b)
                        8'hA4:   cp = 16'h20AC;
                        8'hA6:   cp = 16'h0160;
                        8'hA8:   cp = 16'h0161;
                        8'hB4:   cp = 16'h017D;
                        8'hB8:   cp = 16'h017E;
                        8'hBC:   cp = 16'h0152;
                        8'hBD:   cp = 16'h0153;
                        8'hBE:   cp = 16'h0178;
                        default: cp = {8'h00, b};
                    endcase
                end
                CS_WIN1252: begin
                    if (b < 8'hA0) begin
                        cp = WIN1252_LOW[b[4:0]];
                    end
                end
                CS_LATIN1: cp = {8'h00, b};
                default:   cp = {8'h00, b};
            endcase
        end
        return cp;
    endfunction

endpackage

>>> design/sbcu_lookup.sv
// pipeline stage: byte to unicode code point through the selected table
module sbcu_lookup
    import sbcu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [SEL_W-1:0]  i_sel,
    output t_cp_word          o_word
);

    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic [CP_W-1:0] n_cp;

    assign n_cp = f_code_point(i_sel, i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!i_hold) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_hold) begin
            r_cp <= n_cp;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.cp    = r_cp;

endmodule

>>> design/sbcu_encode.sv
// pipeline stage: code point to one, two or three utf-8 bytes
module sbcu_encode
    import sbcu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_hold,
    input  t_cp_word  i_word,
    output t_enc_word o_word
);

    t_enc_word r_word;
    t_enc_word n_word;

    always_comb begin
        n_word       = '0;
        n_word.valid = i_word.valid;
        if (i_word.cp < 16'h0080) begin
            n_word.b0    = i_word.cp[7:0];
            n_word.count = 2'd1;
            n_word.nul   = (i_word.cp == 16'h0000);
        end else if (i_word.cp < 16'h0800) begin
            n_word.b0    = {3'b110, i_word.cp[10:6]};
            n_word.b1    = {2'b10, i_word.cp[5:0]};
            n_word.count = 2'd2;
        end else begin
            n_word.b0    = {4'b1110, i_word.cp[15:12]};
            n_word.b1    = {2'b10, i_word.cp[11:6]};
            n_word.b2    = {2'b10, i_word.cp[5:0]};
            n_word.count = 2'd3;
        end
    end

    // only the valid bit is reset, the data fields follow it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (!i_hold) begin
            r_word.valid <= n_word.valid;
        end
        if (!i_hold) begin
            r_word.b0    <= n_word.b0;
            r_word.b1    <= n_word.b1;
            r_word.b2    <= n_word.b2;
            r_word.count <= n_word.count;
            r_word.nul   <= n_word.nul;
        end
    end

    assign o_word = r_word;

endmodule

>>> design/sbcu_serial.sv
// output stage: sends the bytes of one character one per cycle
module sbcu_serial
    import sbcu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_enc_word         i_word,
    output logic              o_hold,
    output logic              o_strobe,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last_of_char,
    output logic              o_string_end
);

    logic [BYTE_W-1:0] r_buf [3];
    logic [BYTE_W-1:0] n_buf [3];
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              r_nul;
    logic              n_nul;

    // more bytes of the current character follow, so upstream waits
    assign o_hold = (r_cnt > 2'd1);

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        n_nul = r_nul;
        if (o_hold) begin
            n_buf[0] = r_buf[1];
            n_buf[1] = r_buf[2];
            n_cnt    = r_cnt - 2'd1;
        end else if (i_word.valid) begin
            n_buf[0] = i_word.b0;
            n_buf[1] = i_word.b1;
            n_buf[2] = i_word.b2;
            n_cnt    = i_word.count;
            n_nul    = i_word.nul;
        end else begin
            n_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_nul <= n_nul;
    end

    assign o_strobe       = (r_cnt != 2'd0);
    assign o_out_byte     = r_buf[0];
    assign o_last_of_char = (r_cnt == 2'd1);
    assign o_string_end   = r_nul && (r_cnt == 2'd1);

endmodule

>>> design/single_byte_charset_to_utf8.sv
// top level: single-byte charset to utf-8 transcoder
//
// channel   ports                                            direction
// input     start, busy, i_in_byte                           in, one word per accept
// result    o_strobe, o_out_byte, o_last_of_char,            out, one word per strobe
//           o_string_end
// config    i_cfg_we, i_cfg_wdata                            in, charset select
//
// four stages: capture, table lookup, utf-8 encode, byte output
// a word's first byte leaves from the output register once it has passed capture, lookup and encode
// one word per cycle for ascii while busy is low; multi-byte characters hold off new words,
// since the single output byte lane raises busy while bytes remain
// synchronous active-low reset empties the pipeline and selects iso-8859-15
// the receiver cannot stall; results are never held off
module single_byte_charset_to_utf8
    import sbcu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_cfg_we,
    input  logic [SEL_W-1:0]  i_cfg_wdata,
    output logic              o_strobe,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last_of_char,
    output logic              o_string_end
);

`include "assert_macros.svh"

    logic              hold;
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic [SEL_W-1:0]  r_charset;
    t_cp_word          cp_word;
    t_enc_word         enc_word;

    assign busy = hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charset <= CS_LATIN9;
        end else if (i_cfg_we) begin
            r_charset <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!hold) begin
            r_s1_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold) begin
            r_s1_byte <= i_in_byte;
        end
    end

    sbcu_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (hold),
        .i_valid (r_s1_valid),
        .i_byte  (r_s1_byte),
        .i_sel   (r_charset),
        .o_word  (cp_word)
    );

    sbcu_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (hold),
        .i_word  (cp_word),
        .o_word  (enc_word)
    );

    sbcu_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word         (enc_word),
        .o_hold         (hold),
        .o_strobe       (o_strobe),
        .o_out_byte     (o_out_byte),
        .o_last_of_char (o_last_of_char),
        .o_string_end   (o_string_end)
    );

    // busy only while a multi-byte character is still going out
    `SBCU_ASSERT_SAME(a_busy_strobe, i_clk, i_rst_n, busy, o_strobe && !o_last_of_char)
    // the bytes of one character leave back to back
    `SBCU_ASSERT_NEXT(a_char_contig, i_clk, i_rst_n, o_strobe && !o_last_of_char, o_strobe)
    // the terminator is a lone nul byte
    `SBCU_ASSERT_SAME(a_nul_end, i_clk, i_rst_n, o_strobe && o_string_end,
        o_last_of_char && (o_out_byte == 8'h00))

endmodule

>>> tb/tb_top.sv
// testbench for the single-byte charset to utf-8 transcoder
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sbcu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              nul_end;
    } utf8_byte_t;

    // predicts the utf-8 bytes of each accepted word and compares them in order
    class utf8_scoreboard;
        logic [SEL_W-1:0] charset;
        logic [CP_W-1:0]  cp1252_c1 [32];
        utf8_byte_t       pending_bytes [$];
        int unsigned      mismatches;
        int unsigned      bytes_checked;

        function new();
            charset = CS_LATIN9;
            mismatches = 0;
            bytes_checked = 0;
            cp1252_c1 = '{
                16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
                16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
                16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
                16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
            };
        endfunction

        function logic [CP_W-1:0] code_point(logic [BYTE_W-1:0] ch);
            logic [CP_W-1:0] cp;
            cp = {8'h00, ch};
            if (charset == CS_LATIN9) begin
                case (ch)
                    8'hA4: cp = 16'h20AC;
                    8'hA6: cp = 16'h0160;
                    8'hA8: cp = 16'h0161;
                    8'hB4: cp = 16'h017D;
                    8'hB8: cp = 16'h017E;
                    8'hBC: cp = 16'h0152;
                    8'hBD: cp = 16'h0153;
                    8'hBE: cp = 16'h0178;
                    default: cp = {8'h00, ch};
                endcase
            end else if (charset == CS_WIN1252 && ch < 8'hA0) begin
                cp = cp1252_c1[ch[4:0]];
            end
            return cp;
        endfunction

        function void note_word(logic [BYTE_W-1:0] ch);
            logic [CP_W-1:0] cp;
            if (ch < 8'h80) begin
                pending_bytes.push_back('{ch, 1'b1, ch == 8'h00});
            end else begin
                cp = code_point(ch);
                if (cp < 16'h0800) begin
                    pending_bytes.push_back('{8'hC0 | cp[10:6], 1'b0, 1'b0});
                    pending_bytes.push_back('{8'h80 | cp[5:0], 1'b1, 1'b0});
                end else begin
                    pending_bytes.push_back('{8'hE0 | cp[15:12], 1'b0, 1'b0});
                    pending_bytes.push_back('{8'h80 | cp[11:6], 1'b0, 1'b0});
                    pending_bytes.push_back('{8'h80 | cp[5:0], 1'b1, 1'b0});
                end
            end
        endfunction

        function void check_byte(utf8_byte_t got);
            utf8_byte_t want;
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output byte %02h last %0b end %0b",
                             got.data, got.last, got.nul_end);
                return;
            end
            want = pending_bytes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected byte %02h last %0b end %0b, got %02h %0b %0b",
                             want.data, want.last, want.nul_end,
                             got.data, got.last, got.nul_end);
            end
        endfunction

        function int unsigned outstanding();
            return pending_bytes.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [BYTE_W-1:0] i_in_byte;
    logic              i_cfg_we;
    logic [SEL_W-1:0]  i_cfg_wdata;
    logic              o_strobe;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_last_of_char;
    logic              o_string_end;

    utf8_scoreboard sb;
    int unsigned    cycle_count = 0;
    int unsigned    words_sent;
    int unsigned    sender_idle_pct;
    logic [BYTE_W-1:0] latin9_specials [8] = '{8'hA4, 8'hA6, 8'hA8, 8'hB4,
                                                8'hB8, 8'hBC, 8'hBD, 8'hBE};

    single_byte_charset_to_utf8 i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_in_byte      (i_in_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_out_byte     (o_out_byte),
        .o_last_of_char (o_last_of_char),
        .o_string_end   (o_string_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_byte('{o_out_byte, o_last_of_char, o_string_end});
    end

    // word is accepted at the first edge with busy low while start is high
    task automatic send_word(input logic [BYTE_W-1:0] ch);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_in_byte <= ch;
        do @(posedge i_clk); while (busy);
        sb.note_word(ch);
        words_sent++;
    endtask

    task automatic set_charset(input logic [SEL_W-1:0] sel);
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sel;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.charset = sel;
    endtask

    function automatic logic [BYTE_W-1:0] random_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)  return 8'h00;
        if (r < 40) return BYTE_W'($urandom_range(127, 1));
        if (r < 60) return BYTE_W'($urandom_range(8'h9F, 8'h80));
        if (r < 70) return latin9_specials[3'($urandom_range(7))];
        return BYTE_W'($urandom_range(255, 128));
    endfunction

    initial begin
        logic [BYTE_W-1:0] latin9_directed [14] = '{
            8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF, 8'hA0, 8'hA4, 8'hA6,
            8'hA8, 8'hB4, 8'hB8, 8'hBC, 8'hBD, 8'hBE};
        logic [BYTE_W-1:0] cp1252_directed [11] = '{
            8'h80, 8'h81, 8'h8D, 8'h8F, 8'h90, 8'h9D, 8'h99, 8'h9F,
            8'hA0, 8'hFF, 8'h00};
        logic [SEL_W-1:0] phase_sel [4] = '{CS_LATIN1, CS_WIN1252, 2'd3, CS_LATIN9};
        int unsigned phase_idle [4] = '{0, 71, 0, 17};

        sb = new();
        words_sent = 0;
        sender_idle_pct = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_in_byte   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset default table first, then the windows-1252 c1 area
        foreach (latin9_directed[k]) send_word(latin9_directed[k]);
        set_charset(CS_WIN1252);
        foreach (cp1252_directed[k]) send_word(cp1252_directed[k]);

        // unused selector value 3 is exercised in the third phase
        for (int p = 0; p < 4; p++) begin
            set_charset(phase_sel[p]);
            sender_idle_pct = phase_idle[p];
            for (int n = 0; n < 26; n++) send_word(random_char());
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d words over all four charset selector values, checked %0d bytes",
                 words_sent, sb.bytes_checked);
        $display("mismatches: %0d, bytes still expected: %0d",
                 sb.mismatches, sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
